// ----- design/kcl_pkg.sv -----
// Shared constants for the keypad code lock: key codes, display modes and status codes.
package kcl_pkg;

  localparam int CODE_DIGITS_DEF = 4;
  localparam logic [15:0] HOLD_TICKS_RST = 16'd3000;

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;
  localparam logic [3:0] KEY_LONG_STAR = 4'd12;

  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] DISP_DIGITS = 2'd0;
  localparam logic [1:0] DISP_PROMPT = 2'd1;
  localparam logic [1:0] DISP_OPEN   = 2'd2;
  localparam logic [1:0] DISP_ERR    = 2'd3;

  localparam logic [3:0] ST_NONE      = 4'd0;
  localparam logic [3:0] ST_DIGIT     = 4'd1;
  localparam logic [3:0] ST_FULL      = 4'd2;
  localparam logic [3:0] ST_NEED_ALL  = 4'd3;
  localparam logic [3:0] ST_SAVED     = 4'd4;
  localparam logic [3:0] ST_GRANTED   = 4'd5;
  localparam logic [3:0] ST_DENIED    = 4'd6;
  localparam logic [3:0] ST_RST_ENTER = 4'd7;
  localparam logic [3:0] ST_NO_CODE   = 4'd8;
  localparam logic [3:0] ST_CANCELLED = 4'd9;
  localparam logic [3:0] ST_CLEARED   = 4'd10;
  localparam logic [3:0] ST_ERASED    = 4'd11;
  localparam logic [3:0] ST_WRONG_RST = 4'd12;
  localparam logic [3:0] ST_EXPIRED   = 4'd13;
  localparam logic [3:0] ST_IGNORED   = 4'd14;

endpackage

// ----- design/keypad_code_lock.sv -----
// Keypad code lock: key events and timer ticks in, one lock status word out per input word.
// Each accepted input word's result is computed combinationally and captured in the output register.
// Throughput: one word per cycle while the output is not stalled; the state update is a single pass of
// decode logic and a compare of the entry with the stored code, so the output register alone sets the pace.
// Reset (synchronous, rst_n low): no code stored, empty entry, lamps off, hold time 3000 ticks.
module keypad_code_lock
  import kcl_pkg::*;
#(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [3:0]  in_key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_display_mode,
  output logic [15:0] out_shown_digits,
  output logic [2:0]  out_digits_entered,
  output logic        out_green_led,
  output logic        out_red_led,
  output logic        out_code_is_set,
  output logic        out_in_reset_mode,
  output logic [3:0]  out_status
);

  localparam int ENT_W = 4 * CODE_DIGITS;
  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);

  logic [15:0]      hold_ticks_r;
  logic [ENT_W-1:0] code_r, code_nxt;
  logic             code_vld_r, code_vld_nxt;
  logic [ENT_W-1:0] entry_r, entry_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             showing_r, showing_nxt;
  logic             erase_r, erase_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [1:0]       disp_r, disp_nxt;
  logic             green_r, green_nxt;
  logic             red_r, red_nxt;

  logic             out_valid_r;
  logic [1:0]       o_disp_r;
  logic [15:0]      o_shown_r;
  logic [2:0]       o_cnt_r;
  logic             o_green_r, o_red_r, o_code_set_r, o_erase_r;
  logic [3:0]       o_status_r;

  logic             accept;
  logic             clr;
  logic             match;
  logic [15:0]      elapsed_inc;
  logic [3:0]       status;
  logic [ENT_W+15:0] shown_pad;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign match       = code_vld_r && (entry_r == code_r);
  assign elapsed_inc = (elapsed_r != 16'hFFFF) ? elapsed_r + 16'd1 : elapsed_r;

  always_comb begin
    code_nxt     = code_r;
    code_vld_nxt = code_vld_r;
    entry_nxt    = entry_r;
    cnt_nxt      = cnt_r;
    showing_nxt  = showing_r;
    erase_nxt    = erase_r;
    elapsed_nxt  = elapsed_r;
    disp_nxt     = disp_r;
    green_nxt    = green_r;
    red_nxt      = red_r;
    status       = ST_NONE;
    clr          = 1'b0;

    if (in_kind == KIND_TICK) begin
      if (showing_r) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= hold_ticks_r) begin
          clr      = 1'b1;
          disp_nxt = erase_r ? DISP_PROMPT : DISP_DIGITS;
          status   = ST_EXPIRED;
        end
      end
    end else if (in_key_code == KEY_LONG_STAR) begin
      if (!code_vld_r) begin
        status = ST_NO_CODE;
      end else begin
        clr       = 1'b1;
        erase_nxt = 1'b1;
        disp_nxt  = DISP_PROMPT;
        status    = ST_RST_ENTER;
      end
    end else if (in_key_code == KEY_STAR) begin
      clr       = 1'b1;
      disp_nxt  = DISP_DIGITS;
      erase_nxt = 1'b0;
      status    = erase_r ? ST_CANCELLED : ST_CLEARED;
    end else if (showing_r) begin
      status = ST_IGNORED;
    end else if (in_key_code <= KEY_DIGIT_MAX) begin
      if (cnt_r >= CNT_FULL) begin
        status = ST_FULL;
      end else begin
        // The first digit lands in the top nibble of the entry.
        for (int i = 0; i < CODE_DIGITS; i++) begin
          if (cnt_r == CNT_W'(i)) begin
            entry_nxt[4*(CODE_DIGITS-1-i) +: 4] = in_key_code;
          end
        end
        cnt_nxt  = cnt_r + CNT_W'(1);
        disp_nxt = DISP_DIGITS;
        status   = ST_DIGIT;
      end
    end else if (in_key_code == KEY_HASH) begin
      if (cnt_r != CNT_FULL) begin
        status = ST_NEED_ALL;
      end else if (erase_r) begin
        if (match) begin
          code_nxt     = '0;
          code_vld_nxt = 1'b0;
          erase_nxt    = 1'b0;
          clr          = 1'b1;
          disp_nxt     = DISP_DIGITS;
          status       = ST_ERASED;
        end else begin
          green_nxt   = 1'b0;
          red_nxt     = 1'b1;
          disp_nxt    = DISP_ERR;
          showing_nxt = 1'b1;
          elapsed_nxt = '0;
          status      = ST_WRONG_RST;
        end
      end else if (!code_vld_r) begin
        code_nxt     = entry_r;
        code_vld_nxt = 1'b1;
        clr          = 1'b1;
        disp_nxt     = DISP_DIGITS;
        status       = ST_SAVED;
      end else begin
        green_nxt   = match;
        red_nxt     = !match;
        disp_nxt    = match ? DISP_OPEN : DISP_ERR;
        showing_nxt = 1'b1;
        elapsed_nxt = '0;
        status      = match ? ST_GRANTED : ST_DENIED;
      end
    end else begin
      status = ST_IGNORED;
    end

    if (clr) begin
      cnt_nxt     = '0;
      entry_nxt   = '0;
      showing_nxt = 1'b0;
      elapsed_nxt = '0;
      green_nxt   = 1'b0;
      red_nxt     = 1'b0;
    end
  end

  // Only the first four digits are shown; shorter codes pad with zeros.
  assign shown_pad = {entry_nxt, 16'h0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= HOLD_TICKS_RST;
      code_r       <= '0;
      code_vld_r   <= 1'b0;
      entry_r      <= '0;
      cnt_r        <= '0;
      showing_r    <= 1'b0;
      erase_r      <= 1'b0;
      elapsed_r    <= '0;
      disp_r       <= DISP_DIGITS;
      green_r      <= 1'b0;
      red_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hold_ticks_r <= cfg_wr_data;
      end
      if (accept) begin
        code_r      <= code_nxt;
        code_vld_r  <= code_vld_nxt;
        entry_r     <= entry_nxt;
        cnt_r       <= cnt_nxt;
        showing_r   <= showing_nxt;
        erase_r     <= erase_nxt;
        elapsed_r   <= elapsed_nxt;
        disp_r      <= disp_nxt;
        green_r     <= green_nxt;
        red_r       <= red_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_disp_r     <= disp_nxt;
      o_shown_r    <= shown_pad[ENT_W+15 -: 16];
      o_cnt_r      <= 3'(cnt_nxt);
      o_green_r    <= green_nxt;
      o_red_r      <= red_nxt;
      o_code_set_r <= code_vld_nxt;
      o_erase_r    <= erase_nxt;
      o_status_r   <= status;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_display_mode   = o_disp_r;
  assign out_shown_digits   = o_shown_r;
  assign out_digits_entered = o_cnt_r;
  assign out_green_led      = o_green_r;
  assign out_red_led        = o_red_r;
  assign out_code_is_set    = o_code_set_r;
  assign out_in_reset_mode  = o_erase_r;
  assign out_status         = o_status_r;

endmodule

// ----- dv/keypad_code_lock_tb.sv -----
// Self-checking testbench for the keypad code lock: directed table, then random key and tick sequences.
`timescale 1ns / 1ps

module keypad_code_lock_tb;
  import kcl_pkg::*;

  localparam logic       KIND_KEY   = 1'b0;
  localparam logic [3:0] KEY_UNUSED = 4'd13;
  localparam int         DIR_SPLIT  = 18;
  localparam int         DIR_ROWS   = 25;
  localparam int         PHASE_WORDS = 272;

  typedef struct packed {
    logic [1:0]  disp;
    logic [15:0] digits;
    logic [2:0]  count;
    logic        green;
    logic        red;
    logic        is_set;
    logic        erasing;
    logic [3:0]  status;
  } lock_view_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] key;
    logic       typed;
    lock_view_t view;
  } dir_row_t;

  localparam lock_view_t NO_VIEW = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [3:0]  in_key_code = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_display_mode;
  logic [15:0] out_shown_digits;
  logic [2:0]  out_digits_entered;
  logic        out_green_led;
  logic        out_red_led;
  logic        out_code_is_set;
  logic        out_in_reset_mode;
  logic [3:0]  out_status;

  // A typed result travels with its word so the monitor can queue it on acceptance.
  logic       row_typed = 1'b0;
  lock_view_t row_view = '0;

  lock_view_t expected_views[$];
  int         fail_count = 0;
  int         sent_words = 0;
  bit         quiet = 1'b0;
  bit         tx_calm = 1'b0;

  // Lock state as predicted from the accepted words.
  logic [15:0] hold_cfg;
  logic [15:0] code_word;
  logic        code_set;
  logic [15:0] entry_word;
  int          entry_n;
  logic        showing;
  logic        erase_req;
  logic [15:0] hold_cnt;
  logic [1:0]  disp_sel;
  logic        green_on;
  logic        red_on;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_TICK, 4'hF, 1'b1,
      '{DISP_DIGITS, 16'h0000, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_NONE}},
    '{KIND_KEY, KEY_LONG_STAR, 1'b1,
      '{DISP_DIGITS, 16'h0000, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_NO_CODE}},
    '{KIND_KEY, KEY_HASH, 1'b1,
      '{DISP_DIGITS, 16'h0000, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_NEED_ALL}},
    '{KIND_KEY, KEY_UNUSED, 1'b1,
      '{DISP_DIGITS, 16'h0000, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_IGNORED}},
    '{KIND_KEY, 4'd9, 1'b1,
      '{DISP_DIGITS, 16'h9000, 3'd1, 1'b0, 1'b0, 1'b0, 1'b0, ST_DIGIT}},
    '{KIND_KEY, 4'd0, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd9, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd0, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd5, 1'b0, NO_VIEW},
    '{KIND_KEY, KEY_HASH, 1'b1,
      '{DISP_DIGITS, 16'h0000, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0, ST_SAVED}},
    '{KIND_KEY, 4'd9, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd0, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd9, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd0, 1'b0, NO_VIEW},
    '{KIND_KEY, KEY_HASH, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd1, 1'b0, NO_VIEW},
    '{KIND_TICK, 4'hF, 1'b0, NO_VIEW},
    '{KIND_KEY, KEY_LONG_STAR, 1'b1,
      '{DISP_PROMPT, 16'h0000, 3'd0, 1'b0, 1'b0, 1'b1, 1'b1, ST_RST_ENTER}},
    '{KIND_KEY, 4'd1, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd2, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd3, 1'b0, NO_VIEW},
    '{KIND_KEY, 4'd4, 1'b0, NO_VIEW},
    '{KIND_KEY, KEY_HASH, 1'b0, NO_VIEW},
    '{KIND_TICK, 4'h0, 1'b1,
      '{DISP_PROMPT, 16'h0000, 3'd0, 1'b0, 1'b0, 1'b1, 1'b1, ST_EXPIRED}},
    '{KIND_KEY, KEY_STAR, 1'b1,
      '{DISP_DIGITS, 16'h0000, 3'd0, 1'b0, 1'b0, 1'b1, 1'b0, ST_CANCELLED}}
  };

  keypad_code_lock dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_key_code        (in_key_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_display_mode   (out_display_mode),
    .out_shown_digits   (out_shown_digits),
    .out_digits_entered (out_digits_entered),
    .out_green_led      (out_green_led),
    .out_red_led        (out_red_led),
    .out_code_is_set    (out_code_is_set),
    .out_in_reset_mode  (out_in_reset_mode),
    .out_status         (out_status)
  );

  always #10 clk = ~clk;

  function automatic void lock_clear();
    entry_n = 0;
    entry_word = 16'd0;
    showing = 1'b0;
    hold_cnt = 16'd0;
    green_on = 1'b0;
    red_on = 1'b0;
    disp_sel = DISP_DIGITS;
  endfunction

  function automatic void lock_reset();
    hold_cfg = HOLD_TICKS_RST;
    code_word = 16'd0;
    code_set = 1'b0;
    erase_req = 1'b0;
    lock_clear();
  endfunction

  function automatic void lock_show(logic ok);
    green_on = ok;
    red_on = !ok;
    disp_sel = ok ? DISP_OPEN : DISP_ERR;
    showing = 1'b1;
    hold_cnt = 16'd0;
  endfunction

  function automatic lock_view_t lock_predict(logic kind, logic [3:0] key);
    logic [3:0] st;
    logic       hit;
    lock_view_t v;
    st = ST_NONE;
    if (kind == KIND_TICK) begin
      if (showing) begin
        if (hold_cnt != 16'hFFFF) hold_cnt = hold_cnt + 16'd1;
        if (hold_cnt >= hold_cfg) begin
          lock_clear();
          if (erase_req) disp_sel = DISP_PROMPT;
          st = ST_EXPIRED;
        end
      end
    end else if (key == KEY_LONG_STAR) begin
      if (!code_set) begin
        st = ST_NO_CODE;
      end else begin
        lock_clear();
        erase_req = 1'b1;
        disp_sel = DISP_PROMPT;
        st = ST_RST_ENTER;
      end
    end else if (key == KEY_STAR) begin
      lock_clear();
      st = erase_req ? ST_CANCELLED : ST_CLEARED;
      erase_req = 1'b0;
    end else if (showing) begin
      st = ST_IGNORED;
    end else if (key <= KEY_DIGIT_MAX) begin
      if (entry_n >= CODE_DIGITS_DEF) begin
        st = ST_FULL;
      end else begin
        entry_word = entry_word | ({12'd0, key} << (4 * (CODE_DIGITS_DEF - 1 - entry_n)));
        entry_n++;
        disp_sel = DISP_DIGITS;
        st = ST_DIGIT;
      end
    end else if (key == KEY_HASH) begin
      if (entry_n != CODE_DIGITS_DEF) begin
        st = ST_NEED_ALL;
      end else begin
        hit = code_set && (entry_word == code_word);
        if (erase_req) begin
          if (hit) begin
            code_word = 16'd0;
            code_set = 1'b0;
            erase_req = 1'b0;
            lock_clear();
            st = ST_ERASED;
          end else begin
            lock_show(1'b0);
            st = ST_WRONG_RST;
          end
        end else if (!code_set) begin
          code_word = entry_word;
          code_set = 1'b1;
          lock_clear();
          st = ST_SAVED;
        end else begin
          lock_show(hit);
          st = hit ? ST_GRANTED : ST_DENIED;
        end
      end
    end else begin
      st = ST_IGNORED;
    end
    v = '{disp_sel, entry_word, 3'(entry_n), green_on, red_on, code_set, erase_req, st};
    return v;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    lock_view_t predicted;
    lock_view_t want;
    if (!rst_n) begin
      lock_reset();
    end else begin
      if (cfg_wr_en) hold_cfg = cfg_wr_data;
      if (in_valid && !in_stall) begin
        predicted = lock_predict(in_kind, in_key_code);
        expected_views.push_back(row_typed ? row_view : predicted);
      end
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          $error("result word arrived with nothing expected");
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          check_field("display_mode", want.disp, out_display_mode);
          check_field("shown_digits", want.digits, out_shown_digits);
          check_field("digits_entered", want.count, out_digits_entered);
          check_field("green_led", want.green, out_green_led);
          check_field("red_led", want.red, out_red_led);
          check_field("code_is_set", want.is_set, out_code_is_set);
          check_field("in_reset_mode", want.erasing, out_in_reset_mode);
          check_field("status", want.status, out_status);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic kind, logic [3:0] key, logic typed, lock_view_t view);
    int gap;
    if (!quiet && !tx_calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key_code <= key;
    row_typed <= typed;
    row_view <= view;
    do @(posedge clk); while (in_stall);
    sent_words++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_word(KIND_TICK, 4'($urandom_range(0, 15)), 1'b0, NO_VIEW);
  endtask

  task automatic set_hold(logic [15:0] ticks);
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ticks;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A code attempt: mostly four digits, often the stored code or a near miss.
  task automatic try_code();
    int          n;
    int          j;
    logic [15:0] guess;
    for (j = 0; j < 4; j++) guess[4*j +: 4] = 4'($urandom_range(0, 9));
    if (code_set && $urandom_range(0, 1) == 1) begin
      guess = code_word;
      if ($urandom_range(0, 3) == 0) guess[4*$urandom_range(0, 3) +: 4] = 4'($urandom_range(0, 9));
    end
    n = ($urandom_range(0, 9) < 8) ? 4 : $urandom_range(0, 6);
    for (j = 0; j < n; j++) begin
      if (j < 4) send_word(KIND_KEY, guess[4*(3-j) +: 4], 1'b0, NO_VIEW);
      else send_word(KIND_KEY, 4'($urandom_range(0, 9)), 1'b0, NO_VIEW);
    end
    if ($urandom_range(0, 9) != 0) send_word(KIND_KEY, KEY_HASH, 1'b0, NO_VIEW);
    if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 4)) send_tick();
  endtask

  task automatic play_sequence();
    int pick;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      try_code();
    end else if (pick < 56) begin
      send_word(KIND_KEY, KEY_LONG_STAR, 1'b0, NO_VIEW);
    end else if (pick < 64) begin
      send_word(KIND_KEY, KEY_STAR, 1'b0, NO_VIEW);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 6)) send_tick();
    end else begin
      repeat ($urandom_range(1, 4))
        send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 1'b0, NO_VIEW);
    end
  endtask

  // Result side: stall bursts with calm stretches, plus one long hold-off that backs up the lock.
  initial begin : receiver
    int cyc;
    int n;
    bit long_done;
    cyc = 0;
    long_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (!quiet && !long_done && cyc >= 900) begin
        out_stall <= 1'b1;
        repeat (120) @(negedge clk);
        out_stall <= 1'b0;
        cyc += 120;
        long_done = 1'b1;
      end else if (!quiet && (cyc % 160) >= 50 && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
        cyc += n;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] hold_plan [7];
    int          i;
    int          target;
    hold_plan = '{16'd1, 16'd2, 16'hFFFF, 16'd0, 16'd3, 16'd6, 16'd2};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // The first rows run with the hold time left at its reset value.
    for (i = 0; i < DIR_SPLIT; i++)
      send_word(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].view);
    set_hold(16'd0);
    for (i = DIR_SPLIT; i < DIR_ROWS; i++)
      send_word(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].view);
    for (i = 0; i < 7; i++) begin
      if (i == 5) hold_plan[i] = 16'($urandom_range(4, 9));
      set_hold(hold_plan[i]);
      if (i == 6) begin
        quiet = 1'b1;
        tx_calm = 1'b1;
      end
      target = sent_words + PHASE_WORDS;
      while (sent_words < target) play_sequence();
    end
    in_valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
design/kcl_pkg.sv
design/keypad_code_lock.sv
dv/keypad_code_lock_tb.sv
